@@ sv/bqlpf_pkg.sv @@
// Shared types, constants and helpers for the biquad low-pass filter core.
// Holds the sequencer state and phase enums, register indexes and the
// 64-bit saturating clamp used by the shared adder. No dependencies.
package bqlpf_pkg;

  // Coefficient format: signed Q2.22
  localparam int COEF_W    = 24;
  localparam int COEF_FRAC = 22;
  // Delay values carry 8 fractional bits in sample units
  localparam int STATE_FRAC = 8;

  // Working word of the datapath and its exact-sum width
  localparam int ACC_W = 64;
  localparam int SUM_W = ACC_W + 2;

  // Shared multiplier: coefficient times a 23-bit operand chunk
  localparam int MUL_B_W = COEF_FRAC + 1;
  localparam int PROD_W  = COEF_W + MUL_B_W;
  localparam int TOP_W   = ACC_W - 2 * COEF_FRAC;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COEF_W;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_B0     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_A1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_A2 = 2'd2;

  localparam logic signed [ACC_W-1:0]  ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0]  ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] LO_HALF = PROD_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [ACC_W-1:0]  RND_HALF = ACC_W'(1) << (STATE_FRAC - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_MID,
    S_MUL_TOP,
    S_MUL_HI,
    S_MUL_SAT,
    S_MUL_ACC,
    S_GUARD,
    S_SUM_A,
    S_SUM_B,
    S_SUM_C,
    S_ROUND,
    S_DONE
  } state_t;

  // Which coefficient product is in flight
  typedef enum logic [1:0] {
    PH_A1,
    PH_A2,
    PH_B0
  } phase_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] val;
    logic                    ovf;
  } sat_t;

  // Clamp an exact sum to the signed 64-bit range and flag the clamp
  function automatic sat_t sat_clamp(input logic signed [SUM_W-1:0] v);
    sat_t r;
    if (v > SUM_W'(ACC_MAX)) begin
      r.val = ACC_MAX;
      r.ovf = 1'b1;
    end else if (v < SUM_W'(ACC_MIN)) begin
      r.val = ACC_MIN;
      r.ovf = 1'b1;
    end else begin
      r.val = v[ACC_W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ sv/biquad_lowpass_filter_core.sv @@
// Direct-form-II second-order low-pass biquad with one shared multiplier
// and one shared saturating adder under a small sequencer.
// Depends on bqlpf_pkg for types, constants and the clamp helper.
//
//   channel | ports                                         | dir
//   --------+-----------------------------------------------+-----
//   input   | in_valid, in_stall, in_sample                 | in
//   result  | out_valid, out_stall, out_filtered,           | out
//           | out_clipped, out_guard_hit                    |
//   config  | cfg_we, cfg_index, cfg_data                   | in
//
// A new sample is refused while one is in flight; each sample runs three
// coefficient products, each split into three 24x23 partial products on the
// one multiplier, plus the saturating adds that follow them on the one adder.
// The result register is loaded in the sequencer's last step; a stalled result
// holds the sequencer in its last step until the register frees up.
// Synchronous active-low reset clears the delay line, coefficients and control.
module biquad_lowpass_filter_core
  import bqlpf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int STATE_WIDTH  = 40
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_filtered,
  output logic                           out_clipped,
  output logic                           out_guard_hit,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data
);

  localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic signed [COEF_W-1:0]       b0_r, b0_nxt;
  logic signed [COEF_W-1:0]       a1_r, a1_nxt;
  logic signed [COEF_W-1:0]       a2_r, a2_nxt;
  logic signed [STATE_WIDTH-1:0]  d0_r, d0_nxt;
  logic signed [STATE_WIDTH-1:0]  d1_r, d1_nxt;

  logic signed [SAMPLE_WIDTH-1:0] x_r, x_nxt;
  logic signed [ACC_W-1:0]        acc_r, acc_nxt;
  logic signed [ACC_W-1:0]        opd_r, opd_nxt;
  logic signed [PROD_W-1:0]       prod_r, prod_nxt;
  logic signed [COEF_W:0]         lo_r, lo_nxt;
  logic signed [SUM_W-1:0]        hi_r, hi_nxt;
  logic signed [ACC_W-1:0]        m_r, m_nxt;
  logic                           msat_r, msat_nxt;
  logic                           wsat_r, wsat_nxt;
  logic signed [STATE_WIDTH-1:0]  w_r, w_nxt;
  logic                           guard_r, guard_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_filtered_r, out_filtered_nxt;
  logic                           out_clipped_r, out_clipped_nxt;
  logic                           out_guard_hit_r, out_guard_hit_nxt;

  // Shared multiplier
  logic signed [COEF_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  // Shared saturating adder
  logic signed [ACC_W-1:0] add_a;
  logic signed [ACC_W-1:0] add_b;
  logic                    add_sub;
  logic signed [SUM_W-1:0] add_sum;
  sat_t                    add_res;

  logic signed [PROD_W-1:0]       lo_round;
  logic                           hi_sat;
  logic signed [ACC_W-1:0]        hi_clamped;
  logic signed [ACC_W-1:0]        d0_ext;
  logic signed [ACC_W-1:0]        d1_ext;
  logic signed [ACC_W-1:0]        xq;
  logic signed [STATE_WIDTH-1:0]  w_trunc;
  logic                           w_fit;
  logic                           guard;
  logic signed [ACC_W-1:0]        w_sel;
  logic signed [ACC_W-STATE_FRAC-1:0] rnd_q;
  logic signed [SAMPLE_WIDTH-1:0] y_trunc;
  logic                           y_fit;

  assign d0_ext = ACC_W'(d0_r);
  assign d1_ext = ACC_W'(d1_r);
  assign xq     = ACC_W'(x_r) <<< STATE_FRAC;

  always_comb begin
    case (phase_r)
      PH_A1:   mul_a = a1_r;
      PH_A2:   mul_a = a2_r;
      default: mul_a = b0_r;
    endcase
    case (state_r)
      S_MUL_MID: mul_b = {1'b0, opd_r[2*COEF_FRAC-1:COEF_FRAC]};
      S_MUL_TOP: mul_b = {{(MUL_B_W-TOP_W){opd_r[ACC_W-1]}}, opd_r[ACC_W-1:2*COEF_FRAC]};
      default:   mul_b = {1'b0, opd_r[COEF_FRAC-1:0]};
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Low chunk rounded back to 8 fractional bits
  assign lo_round = prod_r + LO_HALF;

  // High partial sum clamps when it leaves the 64-bit range; the minimum counts too
  assign hi_sat     = (hi_r > SUM_W'(ACC_MAX)) || (hi_r <= SUM_W'(ACC_MIN));
  assign hi_clamped = hi_sat ? (hi_r[SUM_W-1] ? ACC_MIN : ACC_MAX) : hi_r[ACC_W-1:0];

  always_comb begin
    add_a   = acc_r;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_r)
      S_MUL_SAT: begin
        add_a = hi_clamped;
        add_b = ACC_W'(lo_r);
      end
      S_MUL_ACC: begin
        add_b   = m_r;
        add_sub = 1'b1;
      end
      S_SUM_A, S_SUM_B: begin
        add_b = d0_ext;
      end
      S_SUM_C: begin
        add_b = d1_ext;
      end
      S_ROUND: begin
        add_a = m_r;
        add_b = RND_HALF;
      end
      default: begin
        add_b = '0;
      end
    endcase
  end

  assign add_sum = add_sub ? (SUM_W'(add_a) - SUM_W'(add_b))
                           : (SUM_W'(add_a) + SUM_W'(add_b));
  assign add_res = sat_clamp(add_sum);

  // Delay overflow check: any clamp on the way, or w outside the state range
  assign w_trunc = acc_r[STATE_WIDTH-1:0];
  assign w_fit   = (ACC_W'(w_trunc) == acc_r);
  assign guard   = wsat_r || !w_fit;
  assign w_sel   = guard ? xq : acc_r;

  assign rnd_q   = add_res.val[ACC_W-1:STATE_FRAC];
  assign y_trunc = acc_r[SAMPLE_WIDTH-1:0];
  assign y_fit   = (ACC_W'(y_trunc) == acc_r);

  always_comb begin
    state_nxt         = state_r;
    phase_nxt         = phase_r;
    b0_nxt            = b0_r;
    a1_nxt            = a1_r;
    a2_nxt            = a2_r;
    d0_nxt            = d0_r;
    d1_nxt            = d1_r;
    x_nxt             = x_r;
    acc_nxt           = acc_r;
    opd_nxt           = opd_r;
    prod_nxt          = prod_r;
    lo_nxt            = lo_r;
    hi_nxt            = hi_r;
    m_nxt             = m_r;
    msat_nxt          = msat_r;
    wsat_nxt          = wsat_r;
    w_nxt             = w_r;
    guard_nxt         = guard_r;
    out_valid_nxt     = out_valid_r;
    out_filtered_nxt  = out_filtered_r;
    out_clipped_nxt   = out_clipped_r;
    out_guard_hit_nxt = out_guard_hit_r;

    if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_B0:     b0_nxt = cfg_data;
        REG_FEEDBACK_A1: a1_nxt = cfg_data;
        REG_FEEDBACK_A2: a2_nxt = cfg_data;
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_nxt     = in_sample;
          acc_nxt   = ACC_W'(in_sample) <<< STATE_FRAC;
          opd_nxt   = d0_ext;
          phase_nxt = PH_A1;
          wsat_nxt  = 1'b0;
          state_nxt = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        prod_nxt  = mul_p;
        state_nxt = S_MUL_MID;
      end
      S_MUL_MID: begin
        prod_nxt  = mul_p;
        lo_nxt    = lo_round[PROD_W-1:COEF_FRAC];
        state_nxt = S_MUL_TOP;
      end
      S_MUL_TOP: begin
        prod_nxt  = mul_p;
        hi_nxt    = SUM_W'(prod_r);
        state_nxt = S_MUL_HI;
      end
      S_MUL_HI: begin
        hi_nxt    = hi_r + (SUM_W'(prod_r) <<< COEF_FRAC);
        state_nxt = S_MUL_SAT;
      end
      S_MUL_SAT: begin
        m_nxt     = add_res.val;
        msat_nxt  = hi_sat | add_res.ovf;
        state_nxt = (phase_r == PH_B0) ? S_ROUND : S_MUL_ACC;
      end
      S_MUL_ACC: begin
        acc_nxt  = add_res.val;
        wsat_nxt = wsat_r | msat_r | add_res.ovf;
        if (phase_r == PH_A1) begin
          opd_nxt   = d1_ext;
          phase_nxt = PH_A2;
          state_nxt = S_MUL_LO;
        end else begin
          state_nxt = S_GUARD;
        end
      end
      S_GUARD: begin
        guard_nxt = guard;
        w_nxt     = w_sel[STATE_WIDTH-1:0];
        acc_nxt   = w_sel;
        state_nxt = S_SUM_A;
      end
      S_SUM_A: begin
        acc_nxt   = add_res.val;
        state_nxt = S_SUM_B;
      end
      S_SUM_B: begin
        acc_nxt   = add_res.val;
        state_nxt = S_SUM_C;
      end
      S_SUM_C: begin
        acc_nxt   = add_res.val;
        opd_nxt   = add_res.val;
        phase_nxt = PH_B0;
        state_nxt = S_MUL_LO;
      end
      S_ROUND: begin
        acc_nxt   = ACC_W'(rnd_q);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hold until the result register is free, then shift the delay line
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt     = 1'b1;
          out_filtered_nxt  = y_fit ? y_trunc : (acc_r[ACC_W-1] ? OUT_MIN : OUT_MAX);
          out_clipped_nxt   = !y_fit;
          out_guard_hit_nxt = guard_r;
          d1_nxt            = d0_r;
          d0_nxt            = w_r;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_A1;
      b0_r        <= '0;
      a1_r        <= '0;
      a2_r        <= '0;
      d0_r        <= '0;
      d1_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      b0_r        <= b0_nxt;
      a1_r        <= a1_nxt;
      a2_r        <= a2_nxt;
      d0_r        <= d0_nxt;
      d1_r        <= d1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r             <= x_nxt;
    acc_r           <= acc_nxt;
    opd_r           <= opd_nxt;
    prod_r          <= prod_nxt;
    lo_r            <= lo_nxt;
    hi_r            <= hi_nxt;
    m_r             <= m_nxt;
    msat_r          <= msat_nxt;
    wsat_r          <= wsat_nxt;
    w_r             <= w_nxt;
    guard_r         <= guard_nxt;
    out_filtered_r  <= out_filtered_nxt;
    out_clipped_r   <= out_clipped_nxt;
    out_guard_hit_r <= out_guard_hit_nxt;
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_filtered  = out_filtered_r;
  assign out_clipped   = out_clipped_r;
  assign out_guard_hit = out_guard_hit_r;

endmodule
